@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg : shared types and codes of the sorted priority queue
// Entry layout, result layout, operation kinds and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int KEY_W    = 32;
	localparam int HANDLE_W = 10;
	localparam int FILL_W   = 9;
	localparam int STATUS_W = 2;

	// operation kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP    = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		entry_t              ent;
		logic [FILL_W-1:0]   fill;
	} result_t;

endpackage

@@ rtl/spq_mem.sv @@
// ----------------------------------------------------------------------------
// spq_mem : slot store of the priority queue
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spq_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  spq_pkg::entry_t   wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output spq_pkg::entry_t   rdata
);

	spq_pkg::entry_t slots [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			slots[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= slots[raddr];
		end
	end

endmodule

@@ rtl/spq_seq.sv @@
// ----------------------------------------------------------------------------
// spq_seq : operation sequencer of the priority queue
// Runs the top-down compare-and-shift pass of an insert and the read of a pop.
// ----------------------------------------------------------------------------
module spq_seq #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int CW    = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [spq_pkg::KEY_W-1:0]     entry_key,
	input  logic [spq_pkg::HANDLE_W-1:0]  entry_handle,
	output logic                          res_valid,
	input  logic                          res_ack,
	output spq_pkg::result_t              res,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output spq_pkg::entry_t               mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr,
	input  spq_pkg::entry_t               mem_rdata
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_PLACE = 5'b00100,
		S_POP   = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	state_t                           state_q, state_d;
	logic [CW-1:0]                    cnt_q, cnt_d;
	logic [AW-1:0]                    idx_q, idx_d;
	spq_pkg::entry_t                  new_q, new_d;
	logic [spq_pkg::STATUS_W-1:0]     st_q, st_d;
	spq_pkg::entry_t                  out_q, out_d;
	logic                             accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_FIN);
	assign res.status = st_q;
	assign res.ent    = out_q;
	assign res.fill   = spq_pkg::FILL_W'(cnt_q);
	assign mem_waddr  = idx_q;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		new_d     = new_q;
		st_d      = st_q;
		out_d     = out_q;
		mem_we    = 1'b0;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					new_d.key    = entry_key;
					new_d.handle = entry_handle;
					st_d         = spq_pkg::ST_OK;
					out_d        = '0;
					if (kind == spq_pkg::KIND_INSERT) begin
						if (cnt_q == FULL_CNT) begin
							st_d    = spq_pkg::ST_FULL;
							state_d = S_FIN;
						end else if (cnt_q == '0) begin
							cnt_d   = cnt_q + 1'b1;
							idx_d   = '0;
							state_d = S_PLACE;
						end else begin
							// start the pass at the first free slot
							cnt_d     = cnt_q + 1'b1;
							idx_d     = AW'(cnt_q);
							mem_re    = 1'b1;
							mem_raddr = AW'(cnt_q - 1'b1);
							state_d   = S_SCAN;
						end
					end else begin
						if (cnt_q == '0) begin
							st_d    = spq_pkg::ST_EMPTY;
							state_d = S_FIN;
						end else begin
							cnt_d     = cnt_q - 1'b1;
							mem_re    = 1'b1;
							mem_raddr = AW'(cnt_q - 1'b1);
							state_d   = S_POP;
						end
					end
				end
			end
			S_SCAN: begin
				mem_we = 1'b1;
				if (!(new_q.key < mem_rdata.key)) begin
					// slot below holds a key not above ours: move it up
					mem_wdata = mem_rdata;
					if (idx_q == AW'(1)) begin
						idx_d   = '0;
						state_d = S_PLACE;
					end else begin
						idx_d     = idx_q - 1'b1;
						mem_re    = 1'b1;
						mem_raddr = AW'({1'b0, idx_q} - (AW+1)'(2));
					end
				end else begin
					mem_wdata = new_q;
					state_d   = S_FIN;
				end
			end
			S_PLACE: begin
				mem_we    = 1'b1;
				mem_wdata = new_q;
				state_d   = S_FIN;
			end
			S_POP: begin
				out_d   = mem_rdata;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (res_ack) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		new_q <= new_d;
		st_q  <= st_d;
		out_q <= out_d;
	end

endmodule

@@ rtl/sorted_min_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_unit : sorted-array minimum priority queue
// Holds (key, handle) entries in decreasing key order; pops the smallest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transaction:
//   kind selects insert (entry_key, entry_handle) or pop. Output channel
//   (out_valid/out_ready) returns exactly one result per operation: status,
//   the popped key and handle (zero unless a pop succeeded) and the fill.
//   Entries live in slots 0..fill-1 of one memory, highest slot smallest;
//   equal keys leave in the order they came in.
//   An insert walks the store from the top down, one slot per cycle over
//   the read port and the write port of the slot memory, moving each entry
//   with a key not above the new one up a place.
//   One operation is in flight at a time; in_ready is high only when the
//   sequencer is idle, but a finished result parked in the output register
//   does not stop the next operation from being taken.
//   Reset empties the queue at once (the fill count clears); no clearing
//   pass runs over the memory. A stalled receiver holds the output register,
//   and a second finished result then waits in the sequencer.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_unit #(
	parameter int DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [spq_pkg::KEY_W-1:0]     entry_key,
	input  logic [spq_pkg::HANDLE_W-1:0]  entry_handle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [spq_pkg::STATUS_W-1:0]  status,
	output logic [spq_pkg::KEY_W-1:0]     out_key,
	output logic [spq_pkg::HANDLE_W-1:0]  out_handle,
	output logic [spq_pkg::FILL_W-1:0]    fill
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	spq_pkg::entry_t      mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	spq_pkg::entry_t      mem_rdata;
	logic                 res_valid;
	logic                 res_ack;
	spq_pkg::result_t     res;
	logic                 out_valid_q;
	spq_pkg::result_t     out_q;

	// slot store
	spq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// operation sequencer
	spq_seq #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.entry_key    (entry_key),
		.entry_handle (entry_handle),
		.res_valid    (res_valid),
		.res_ack      (res_ack),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	// load the output register when it is empty or being drained this cycle
	assign res_ack = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result payload until the receiver takes it
	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign out_key    = out_q.ent.key;
	assign out_handle = out_q.ent.handle;
	assign fill       = out_q.fill;

	// a refused insert or an empty pop never returns an entry
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == spq_pkg::ST_FULL || status == spq_pkg::ST_EMPTY)
		|-> (out_key == '0 && out_handle == '0))
		else $error("rejected operation returned a non-zero entry");

	// an empty pop leaves the queue empty
	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_EMPTY |-> fill == '0)
		else $error("pop on empty reported a non-zero fill");

	// a handed-over result shows on the output in the next cycle
	a_ack_loads: assert property (@(posedge clk) disable iff (!arst_n)
		res_ack |=> out_valid)
		else $error("acknowledged result did not reach the output register");

	// the sequencer never takes a transaction while a result is pending inside
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && res_valid))
		else $error("input taken while a result was still held");

endmodule
